[rtl/rdu_pkg.sv]
// Package for the refraction direction unit: eta register format and
// throughput field constants. No dependencies.
`default_nettype none

package rdu_pkg;

   localparam int ETA_W    = 16;   // eta register width, unsigned Q2.14
   localparam int ETA_FRAC = 14;   // fraction bits of eta
   localparam int TP_W     = 16;   // throughput width, unsigned Q8.8
   localparam int TP_FRAC  = 8;

   localparam logic [ETA_W-1:0] ETA_RESET = 16'd16384;   // 1.0

endpackage

`default_nettype wire

[rtl/refraction_direction_unit.sv]
// Refraction direction unit: Snell refraction of a surface-space direction.
// Accepts one beat per cycle while the output is not stalled.
// The restoring dividers (t/eta^2, tangents, throughput) and the square
// root each retire one bit per pipeline stage; a full stall freezes every stage.
// Synchronous reset empties the pipeline and restores eta_ratio to 1.0.
// Depends on rdu_pkg.
`default_nettype none

module refraction_direction_unit
   import rdu_pkg::*;
#(
   parameter int DIR_WIDTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic signed [DIR_WIDTH-1:0] req_dir_x,
   input  wire logic signed [DIR_WIDTH-1:0] req_dir_y,
   input  wire logic signed [DIR_WIDTH-1:0] req_dir_z,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic signed [DIR_WIDTH-1:0] rsp_out_x,
   output      logic signed [DIR_WIDTH-1:0] rsp_out_y,
   output      logic signed [DIR_WIDTH-1:0] rsp_out_z,
   output      logic [TP_W-1:0]             rsp_throughput,
   output      logic                        rsp_total_internal,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [ETA_W-1:0]            csr_eta_ratio
);

   localparam int W   = DIR_WIDTH;
   localparam int MW  = W + 2*ETA_W - 2*ETA_FRAC;   // direct-path m width
   localparam int TW  = W + ETA_W + 1 - ETA_FRAC;   // tangent magnitude width
   localparam int DCW = W + 2*ETA_W + 2;             // divider compare width
   localparam int SQW = 2*W + 1;                     // sqrt remainder width
   localparam int TCW = W + TP_W + TP_FRAC;          // throughput divider width
   localparam int L   = 2*W + 24;                    // total stages

   localparam logic [W-1:0]   S_VAL  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]   S_M1   = {1'b0, {(W-1){1'b1}}};
   localparam logic [2*W-1:0] SQ_ONE = {2'b01, {(2*W-2){1'b0}}};
   localparam logic [W+ETA_W:0] RND  = (W+ETA_W+1)'(1) << (ETA_FRAC-1);

   typedef struct packed {
      logic              pos;
      logic              neg_x;
      logic              neg_z;
      logic [2*ETA_W-1:0] ee;
      logic [ETA_W-1:0]  e;
      logic [MW-1:0]     m_dir;
      logic [TW-1:0]     tdx;
      logic [TW-1:0]     tdz;
      logic [DCW-1:0]    m_rem;
      logic [DCW-1:0]    x_rem;
      logic [DCW-1:0]    z_rem;
      logic [W:0]        m_q;
      logic [W:0]        x_q;
      logic [W:0]        z_q;
      logic              m_ovf;
      logic              x_ovf;
      logic              z_ovf;
   } div_type;

   typedef struct packed {
      logic           pos;
      logic           tim;
      logic [W-1:0]   out_x;
      logic [W-1:0]   out_z;
      logic [W-1:0]   root;
      logic [SQW-1:0] rem;
   } sq_type;

   typedef struct packed {
      logic           tim;
      logic [W-1:0]   out_x;
      logic [W-1:0]   out_y;
      logic [W-1:0]   out_z;
      logic [W-1:0]   dvs;
      logic [TCW-1:0] rem;
      logic [TP_W-1:0] q;
      logic           ovf;
   } tp_type;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      return v[W-1] ? (~v + W'(1)) : v;
   endfunction

   // -eta*c with saturation: result sign opposite to the input sign
   function automatic logic [W-1:0] tan_out(input logic neg, input logic [TW-1:0] mag);
      logic [W-1:0] lim;
      if (neg) begin
         lim = (mag > TW'(S_M1)) ? S_M1 : mag[W-1:0];
         return lim;
      end
      lim = (mag > TW'(S_VAL)) ? S_VAL : mag[W-1:0];
      return ~lim + W'(1);
   endfunction

   // ---------------------------------------------------------------
   // Control: global advance, valid shift line, eta register
   // ---------------------------------------------------------------
   logic         en;
   logic [L-1:0] vld_ff;
   logic [ETA_W-1:0] eta_ff;

   assign en        = !vld_ff[L-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[L-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[L-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff <= ETA_RESET;
      end else if (csr_valid) begin
         eta_ff <= csr_eta_ratio;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: decode signs and magnitudes, choose eta
   // ---------------------------------------------------------------
   logic             pos_in;
   logic [ETA_W-1:0] e_in;
   logic             pos1_ff, negx1_ff, negz1_ff;
   logic [W-1:0]     ax1_ff, ay1_ff, az1_ff;
   logic [ETA_W-1:0] e1_ff;

   always_comb begin
      pos_in = !req_dir_y[W-1] && (req_dir_y != '0);
      // zero eta on the reciprocal path acts as the smallest nonzero code
      e_in   = (!pos_in && eta_ff == '0) ? ETA_W'(1) : eta_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos1_ff  <= pos_in;
         negx1_ff <= req_dir_x[W-1];
         negz1_ff <= req_dir_z[W-1];
         ax1_ff   <= mag_of(req_dir_x);
         ay1_ff   <= mag_of(req_dir_y);
         az1_ff   <= mag_of(req_dir_z);
         e1_ff    <= e_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: y^2, eta^2 and direct tangent products
   // ---------------------------------------------------------------
   logic                 pos2_ff, negx2_ff, negz2_ff;
   logic [W-1:0]         ax2_ff, az2_ff;
   logic [ETA_W-1:0]     e2_ff;
   logic [2*W-1:0]       ay2_ff;
   logic [2*ETA_W-1:0]   ee2_ff;
   logic [W+ETA_W-1:0]   px2_ff, pz2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pos2_ff  <= pos1_ff;
         negx2_ff <= negx1_ff;
         negz2_ff <= negz1_ff;
         ax2_ff   <= ax1_ff;
         az2_ff   <= az1_ff;
         e2_ff    <= e1_ff;
         ay2_ff   <= (2*W)'(ay1_ff) * (2*W)'(ay1_ff);
         ee2_ff   <= (2*ETA_W)'(e1_ff) * (2*ETA_W)'(e1_ff);
         px2_ff   <= (W+ETA_W)'(ax1_ff) * (W+ETA_W)'(e1_ff);
         pz2_ff   <= (W+ETA_W)'(az1_ff) * (W+ETA_W)'(e1_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: t = 1 - y^2, rounded direct tangents
   // ---------------------------------------------------------------
   logic [2*W-1:0]     diff_in;
   logic [W+ETA_W:0]   sx_in, sz_in;
   logic               pos3_ff, negx3_ff, negz3_ff;
   logic [W-1:0]       ax3_ff, az3_ff, t3_ff;
   logic [ETA_W-1:0]   e3_ff;
   logic [2*ETA_W-1:0] ee3_ff;
   logic [TW-1:0]      tdx3_ff, tdz3_ff;

   always_comb begin
      diff_in = SQ_ONE - ay2_ff;
      sx_in   = (W+ETA_W+1)'(px2_ff) + RND;
      sz_in   = (W+ETA_W+1)'(pz2_ff) + RND;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos3_ff  <= pos2_ff;
         negx3_ff <= negx2_ff;
         negz3_ff <= negz2_ff;
         ax3_ff   <= ax2_ff;
         az3_ff   <= az2_ff;
         e3_ff    <= e2_ff;
         ee3_ff   <= ee2_ff;
         t3_ff    <= diff_in[2*W-2:W-1];
         tdx3_ff  <= sx_in[W+ETA_W:ETA_FRAC];
         tdz3_ff  <= sz_in[W+ETA_W:ETA_FRAC];
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: direct m = t*eta^2, divider setup with overflow precheck
   // ---------------------------------------------------------------
   logic [W+2*ETA_W-1:0] mprod_in;
   div_type              s4_in, s4_ff;

   always_comb begin
      mprod_in      = (W+2*ETA_W)'(t3_ff) * (W+2*ETA_W)'(ee3_ff);
      s4_in.pos     = pos3_ff;
      s4_in.neg_x   = negx3_ff;
      s4_in.neg_z   = negz3_ff;
      s4_in.ee      = ee3_ff;
      s4_in.e       = e3_ff;
      s4_in.m_dir   = mprod_in[W+2*ETA_W-1:2*ETA_FRAC];
      s4_in.tdx     = tdx3_ff;
      s4_in.tdz     = tdz3_ff;
      s4_in.m_rem   = DCW'(t3_ff) << (2*ETA_FRAC);
      s4_in.x_rem   = (DCW'(ax3_ff) << ETA_FRAC) + DCW'(e3_ff >> 1);
      s4_in.z_rem   = (DCW'(az3_ff) << ETA_FRAC) + DCW'(e3_ff >> 1);
      s4_in.m_q     = '0;
      s4_in.x_q     = '0;
      s4_in.z_q     = '0;
      s4_in.m_ovf   = s4_in.m_rem >= (DCW'(ee3_ff) << (W+1));
      s4_in.x_ovf   = s4_in.x_rem >= (DCW'(e3_ff) << (W+1));
      s4_in.z_ovf   = s4_in.z_rem >= (DCW'(e3_ff) << (W+1));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff <= s4_in;
      end
   end

   // ---------------------------------------------------------------
   // Restoring dividers, one quotient bit per stage: t/eta^2, x/eta, z/eta
   // ---------------------------------------------------------------
   div_type div_ff [0:W];

   for (genvar j = 0; j <= W; j++) begin : g_div
      localparam int K = W - j;
      div_type        src, step_in;
      logic [DCW-1:0] mc, ec;

      if (j == 0) begin : g_first
         assign src = s4_ff;
      end else begin : g_next
         assign src = div_ff[j-1];
      end

      always_comb begin
         mc      = DCW'(src.ee) << K;
         ec      = DCW'(src.e) << K;
         step_in = src;
         if (src.m_rem >= mc) begin
            step_in.m_rem  = src.m_rem - mc;
            step_in.m_q[K] = 1'b1;
         end
         if (src.x_rem >= ec) begin
            step_in.x_rem  = src.x_rem - ec;
            step_in.x_q[K] = 1'b1;
         end
         if (src.z_rem >= ec) begin
            step_in.z_rem  = src.z_rem - ec;
            step_in.z_q[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[j] <= step_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: pick m, flag total internal reflection, sqrt setup, tangents
   // ---------------------------------------------------------------
   div_type       dq;
   logic [MW-1:0] m_in;
   logic [W-1:0]  sm_in;
   logic [TW-1:0] magx_in, magz_in;
   sq_type        s5_in, s5_ff;

   always_comb begin
      dq      = div_ff[W];
      m_in    = dq.pos ? dq.m_dir : (dq.m_ovf ? '1 : MW'(dq.m_q));
      sm_in   = S_VAL - m_in[W-1:0];
      magx_in = dq.pos ? dq.tdx : (dq.x_ovf ? '1 : TW'(dq.x_q));
      magz_in = dq.pos ? dq.tdz : (dq.z_ovf ? '1 : TW'(dq.z_q));
      s5_in.pos   = dq.pos;
      s5_in.tim   = m_in > MW'(S_VAL);
      s5_in.out_x = tan_out(dq.neg_x, magx_in);
      s5_in.out_z = tan_out(dq.neg_z, magz_in);
      s5_in.root  = '0;
      s5_in.rem   = SQW'(sm_in) << (W-1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff <= s5_in;
      end
   end

   // ---------------------------------------------------------------
   // Square root, one root bit per stage
   // ---------------------------------------------------------------
   sq_type sq_ff [0:W-1];

   for (genvar j = 0; j < W; j++) begin : g_sqrt
      localparam int I = W - 1 - j;
      sq_type         src, step_in;
      logic [SQW-1:0] inc;

      if (j == 0) begin : g_first
         assign src = s5_ff;
      end else begin : g_next
         assign src = sq_ff[j-1];
      end

      always_comb begin
         // (r + 2^I)^2 - r^2
         inc     = (SQW'(src.root) << (I+1)) + (SQW'(1) << (2*I));
         step_in = src;
         if (src.rem >= inc) begin
            step_in.rem     = src.rem - inc;
            step_in.root[I] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j] <= step_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: clamp and sign out_y, throughput divider setup
   // ---------------------------------------------------------------
   sq_type       sr;
   logic [W-1:0] magc_in;
   tp_type       s6_in, s6_ff;

   always_comb begin
      sr = sq_ff[W-1];
      if (sr.pos) begin
         magc_in = (sr.root > S_VAL) ? S_VAL : sr.root;
      end else begin
         magc_in = (sr.root > S_M1) ? S_M1 : sr.root;
      end
      s6_in.tim   = sr.tim;
      s6_in.out_x = sr.out_x;
      s6_in.out_z = sr.out_z;
      s6_in.out_y = sr.pos ? (~magc_in + W'(1)) : magc_in;
      s6_in.dvs   = magc_in;
      s6_in.rem   = TCW'(1) << (W - 1 + TP_FRAC);
      s6_in.q     = '0;
      // also catches a zero magnitude
      s6_in.ovf   = s6_in.rem >= (TCW'(magc_in) << TP_W);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ff <= s6_in;
      end
   end

   // ---------------------------------------------------------------
   // Throughput divider, one bit per stage
   // ---------------------------------------------------------------
   tp_type tp_ff [0:TP_W-1];

   for (genvar j = 0; j < TP_W; j++) begin : g_tp
      localparam int K = TP_W - 1 - j;
      tp_type         src, step_in;
      logic [TCW-1:0] dc;

      if (j == 0) begin : g_first
         assign src = s6_ff;
      end else begin : g_next
         assign src = tp_ff[j-1];
      end

      always_comb begin
         dc      = TCW'(src.dvs) << K;
         step_in = src;
         if (src.rem >= dc) begin
            step_in.rem  = src.rem - dc;
            step_in.q[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tp_ff[j] <= step_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register: zero the directions and throughput on total internal reflection
   // ---------------------------------------------------------------
   tp_type          tf;
   logic [W-1:0]    out_x_ff, out_y_ff, out_z_ff;
   logic [TP_W-1:0] tp_out_ff;
   logic            tim_ff;

   assign tf = tp_ff[TP_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         tim_ff    <= tf.tim;
         out_x_ff  <= tf.tim ? '0 : tf.out_x;
         out_y_ff  <= tf.tim ? '0 : tf.out_y;
         out_z_ff  <= tf.tim ? '0 : tf.out_z;
         tp_out_ff <= tf.tim ? '0 : (tf.ovf ? '1 : tf.q);
      end
   end

   assign rsp_out_x          = out_x_ff;
   assign rsp_out_y          = out_y_ff;
   assign rsp_out_z          = out_z_ff;
   assign rsp_throughput     = tp_out_ff;
   assign rsp_total_internal = tim_ff;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for refraction_direction_unit: random and edge-case directions under
// several eta settings, checked beat by beat against a built-in Snell predictor.
// Depends on rdu_pkg and the refraction_direction_unit RTL.
`timescale 1ns / 1ps

module tb_top;
   import rdu_pkg::*;

   localparam int W     = 16;
   localparam int DRAIN = 2 * W + 40;   // pipeline depth plus margin

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] z;
   } ray_type;

   typedef struct packed {
      logic signed [W-1:0] ox;
      logic signed [W-1:0] oy;
      logic signed [W-1:0] oz;
      logic [TP_W-1:0]     tp;
      logic                tir;
   } refr_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic signed [W-1:0] req_dir_x = '0;
   logic signed [W-1:0] req_dir_y = '0;
   logic signed [W-1:0] req_dir_z = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_out_x;
   logic signed [W-1:0] rsp_out_y;
   logic signed [W-1:0] rsp_out_z;
   logic [TP_W-1:0]     rsp_throughput;
   logic                rsp_total_internal;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ETA_W-1:0]    csr_eta_ratio = '0;

   refraction_direction_unit #(.DIR_WIDTH(W)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus state
   ray_type          ray_q[$];        // directions waiting to be driven
   refr_type         refr_q[$];       // predicted refractions, oldest first
   logic [ETA_W-1:0] eta_now = ETA_RESET;
   int               send_idle = 21;  // percent of cycles the sender holds off
   int               recv_idle = 45;  // percent of cycles the receiver stalls
   int               errors = 0;
   bit               req_taken = 1'b0;
   ray_type          cur_ray;

   // Bitwise integer square root, floor.
   function automatic longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // -eta * c on the direct path, -c / eta otherwise, round half away from zero, saturate to the signed range.
   function automatic logic [W-1:0] bend(logic signed [W-1:0] c, bit direct,
                                         longint unsigned e);
      longint unsigned s, a, mag;
      longint          cs;
      s  = 64'd1 << (W - 1);
      cs = c;
      a  = (cs < 0) ? -cs : cs;
      if (direct) mag = (a * e + (64'd1 << (ETA_FRAC - 1))) >> ETA_FRAC;
      else        mag = ((a << ETA_FRAC) + e / 2) / e;
      if (cs < 0) begin
         if (mag > s - 1) mag = s - 1;
         return mag[W-1:0];
      end
      if (mag > s) mag = s;
      return W'(-mag);
   endfunction

   // Refracted direction for one incoming ray at the given eta.
   function automatic refr_type refract(ray_type d, logic [ETA_W-1:0] eta);
      longint unsigned s, e, ay, t, m, mag, tp;
      longint          ys;
      bit              direct;
      refr_type        r;
      s      = 64'd1 << (W - 1);
      ys     = d.y;
      direct = ys > 0;
      e      = eta;
      if (!direct && e == 0) e = 1;        // zero eta on the inside: take 1
      ay = (ys < 0) ? -ys : ys;
      t  = (s * s - ay * ay) / s;
      if (direct) m = (t * (e * e)) >> (2 * ETA_FRAC);
      else        m = (t << (2 * ETA_FRAC)) / (e * e);
      r = '0;
      if (m > s) begin                     // total internal reflection
         r.tir = 1'b1;
         return r;
      end
      mag = root((s - m) * s);
      if (direct) begin
         if (mag > s) mag = s;
         r.oy = W'(-mag);
      end else begin
         if (mag > s - 1) mag = s - 1;
         r.oy = mag[W-1:0];
      end
      if (mag == 0) tp = 65535;
      else begin
         tp = (s << TP_FRAC) / mag;
         if (tp > 65535) tp = 65535;
      end
      r.tp = tp[TP_W-1:0];
      r.ox = bend(d.x, direct, e);
      r.oz = bend(d.z, direct, e);
      return r;
   endfunction

   // Acceptance and prediction on the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         refr_q.push_back(refract(cur_ray, eta_now));
         req_taken = 1'b1;
      end
   end

   // Driver: new beats launched on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (ray_q.size() != 0 && $urandom_range(99) >= send_idle) begin
            cur_ray = ray_q.pop_front();
            req_dir_x <= cur_ray.x;
            req_dir_y <= cur_ray.y;
            req_dir_z <= cur_ray.z;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // Monitor: compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      refr_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_throughput, rsp_total_internal};
         if (refr_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, got %h", $time, got);
         end else begin
            want = refr_q.pop_front();
            if (got.ox !== want.ox)
               $display("%0t: out_x exp %0d got %0d", $time, want.ox, got.ox);
            if (got.oy !== want.oy)
               $display("%0t: out_y exp %0d got %0d", $time, want.oy, got.oy);
            if (got.oz !== want.oz)
               $display("%0t: out_z exp %0d got %0d", $time, want.oz, got.oz);
            if (got.tp !== want.tp)
               $display("%0t: throughput exp %0d got %0d", $time, want.tp, got.tp);
            if (got.tir !== want.tir)
               $display("%0t: total_internal exp %0b got %0b", $time, want.tir, got.tir);
            if (got !== want) errors++;
         end
      end
   end

   // Block goes idle: all beats sent, all results back, pipeline flushed.
   task automatic drain();
      wait (ray_q.size() == 0 && !req_valid);
      wait (refr_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_eta(logic [ETA_W-1:0] v);
      @(negedge clock);
      csr_eta_ratio <= v;
      csr_valid     <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      eta_now = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [W-1:0] pick();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'sh0001;
         4: return 16'shFFFF;
         default: return W'($urandom);
      endcase
   endfunction

   // Edge cases: zero, +/-1, full-scale normal, saturation of tangents.
   task automatic push_edges();
      logic signed [W-1:0] ys[8] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001,
                                     16'shFFFF, 16'sh4000, 16'shC000, 16'sh5A82};
      foreach (ys[i]) begin
         ray_q.push_back('{16'sh8000, ys[i], 16'sh7FFF});
         ray_q.push_back('{16'sh7FFF, ys[i], 16'sh8000});
      end
      ray_q.push_back('{16'sh5555, 16'shAAAA, 16'sh0000});
   endtask

   initial begin
      logic [ETA_W-1:0] etas[10];
      etas = '{ETA_RESET, 16'd4096, 16'd65535, 16'd0, 16'd1,
               16'd23170, 16'd11585, 16'd32768, 16'd0, 16'd0};
      etas[8] = ETA_W'($urandom_range(4096, 65535));
      etas[9] = ETA_W'($urandom);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (etas[p]) begin
         if (p == 3) begin
            send_idle = 45;
            recv_idle = 21;
         end else if (p == 7) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (p != 0) write_eta(etas[p]);   // reset value covers the first setting
         push_edges();
         repeat (200) ray_q.push_back('{pick(), pick(), pick()});
         drain();                          // sender holds off until all came back
      end
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
rtl/rdu_pkg.sv
rtl/refraction_direction_unit.sv
sim/tb_top.sv
